[src/dds_pkg.sv]
`timescale 1ns / 1ps
// dds_pkg: shared types and constants for the dense shortest-path block
// no dependencies

package dds_pkg;

    localparam int DDS_MAX_VERTICES = 64;

    localparam int VCOUNT_W = 7;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    localparam int DIST_W = 30;
    localparam int MAT_W  = 16;
    // distance memory entry: visited flag on top of the distance
    localparam int DENT_W = DIST_W + 1;

    localparam logic [DIST_W-1:0] DIST_INF = 30'd1000000000;

    typedef struct packed {
        logic        edge_valid;
        logic [5:0]  edge_from;
        logic [5:0]  edge_to;
        logic [14:0] edge_weight;
        logic        load_done;
    } t_item;

    typedef struct packed {
        logic [5:0]        vertex;
        logic [DIST_W-1:0] distance;
        logic              last_result;
    } t_result;

endpackage

[src/dds_ram.sv]
`timescale 1ns / 1ps
// dds_ram: generic single-write, single-read ram with registered read data
// no dependencies

module dds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/dds_core.sv]
`timescale 1ns / 1ps
// dds_core: sequencer for loading, dijkstra passes, result readout and matrix clear
// depends on dds_pkg and dds_ram

module dds_core #(
    parameter int MAX_VERTICES = dds_pkg::DDS_MAX_VERTICES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  dds_pkg::t_item                    i_item,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] i_n,
    output logic                              o_busy,
    output logic                              o_strobe,
    output dds_pkg::t_result                  o_result
);

    import dds_pkg::*;

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int CW        = $clog2(MAX_VERTICES + 1);
    localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW        = $clog2(MAT_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAT_DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_RELAX = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_v, n_v;
    logic              r_pvld, n_pvld;
    logic [CW-1:0]     r_pv, n_pv;
    logic [CW-1:0]     r_pass, n_pass;
    logic              r_found, n_found;
    logic [VW-1:0]     r_u, n_u;
    logic [DIST_W-1:0] r_du, n_du;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;

    logic              mat_we;
    logic [AW-1:0]     mat_waddr;
    logic [MAT_W-1:0]  mat_wdata;
    logic [AW-1:0]     mat_raddr;
    logic [MAT_W-1:0]  mat_rdata;
    logic              dist_we;
    logic [VW-1:0]     dist_waddr;
    logic [DENT_W-1:0] dist_wdata;
    logic [VW-1:0]     dist_raddr;
    logic [DENT_W-1:0] dist_rdata;

    logic              acc;
    logic              edge_ok;
    logic              issue;
    logic              rd_vis;
    logic [DIST_W-1:0] rd_dist;
    logic [DIST_W:0]   cand;
    logic [CW-1:0]     n_last;

    dds_ram #(
        .WIDTH (MAT_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    dds_ram #(
        .WIDTH (DENT_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    assign acc     = i_start && (r_state == S_IDLE);
    assign edge_ok = i_item.edge_valid
                     && (32'(i_item.edge_from) < 32'(MAX_VERTICES))
                     && (32'(i_item.edge_to) < 32'(MAX_VERTICES));
    assign issue   = (r_v != i_n);
    assign rd_vis  = dist_rdata[DENT_W-1];
    assign rd_dist = dist_rdata[DIST_W-1:0];
    // stored weights carry a +1 offset, zero means no edge
    assign cand    = {1'b0, r_du} + (DIST_W+1)'(mat_rdata) - (DIST_W+1)'(1);
    assign n_last  = i_n - CW'(1);

    assign mat_raddr  = (r_state == S_RELAX)
                        ? AW'(r_u) * AW'(MAX_VERTICES) + AW'(r_v[VW-1:0])
                        : AW'(r_v[VW-1:0]);
    assign dist_raddr = r_v[VW-1:0];

    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_pvld   = 1'b0;
        n_pv     = r_pv;
        n_pass   = r_pass;
        n_found  = r_found;
        n_u      = r_u;
        n_du     = r_du;
        n_clr    = r_clr;
        n_strobe = 1'b0;
        n_result = r_result;

        mat_we     = 1'b0;
        mat_waddr  = AW'(i_item.edge_from) * AW'(MAX_VERTICES) + AW'(i_item.edge_to);
        mat_wdata  = MAT_W'(i_item.edge_weight) + MAT_W'(1);
        dist_we    = 1'b0;
        dist_waddr = r_pv[VW-1:0];
        dist_wdata = {1'b0, rd_dist};

        // read pipeline shared by the sweeping states
        if (issue) begin
            n_v    = r_v + CW'(1);
            n_pv   = r_v;
            n_pvld = (r_state == S_INIT) || (r_state == S_SCAN)
                     || (r_state == S_RELAX) || (r_state == S_OUT);
        end

        case (r_state)
            S_CLEAR: begin
                mat_we    = 1'b1;
                mat_waddr = r_clr;
                mat_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                    n_clr   = '0;
                end
            end
            S_IDLE: begin
                n_pvld = 1'b0;
                n_v    = CW'(1);
                if (acc) begin
                    mat_we = edge_ok;
                    if (i_item.load_done) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (r_pvld) begin
                    dist_we    = 1'b1;
                    dist_wdata = {1'b0, (mat_rdata == '0) ? DIST_INF
                                        : DIST_W'(mat_rdata - MAT_W'(1))};
                end
                if (!issue) begin
                    n_state = S_SCAN;
                    n_v     = CW'(1);
                    n_pass  = CW'(1);
                    n_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_pvld && !rd_vis && (!r_found || (rd_dist < r_du))) begin
                    n_found = 1'b1;
                    n_u     = r_pv[VW-1:0];
                    n_du    = rd_dist;
                end
                if (!issue) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                n_pvld = 1'b0;
                n_v    = CW'(1);
                if (r_found) begin
                    dist_we    = 1'b1;
                    dist_waddr = r_u;
                    dist_wdata = {1'b1, r_du};
                    n_state    = S_RELAX;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RELAX: begin
                // writes land one entry behind the read, so no overlap on an entry
                if (r_pvld && !rd_vis && (mat_rdata != '0) && ({1'b0, rd_dist} > cand)) begin
                    dist_we    = 1'b1;
                    dist_wdata = {1'b0, cand[DIST_W-1:0]};
                end
                if (!issue) begin
                    n_v     = CW'(1);
                    n_found = 1'b0;
                    if (r_pass == n_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_pass  = r_pass + CW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_OUT: begin
                if (r_pvld) begin
                    n_strobe             = 1'b1;
                    n_result.vertex      = 6'(r_pv);
                    n_result.distance    = rd_dist;
                    n_result.last_result = (r_pv == n_last);
                end
                if (!issue) begin
                    n_state = S_CLEAR;
                    n_clr   = '0;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pvld   <= 1'b0;
            r_strobe <= 1'b0;
            r_v      <= CW'(1);
            r_pass   <= CW'(1);
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pvld   <= n_pvld;
            r_strobe <= n_strobe;
            r_v      <= n_v;
            r_pass   <= n_pass;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pv     <= n_pv;
        r_u      <= n_u;
        r_du     <= n_du;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[src/dense_dijkstra_shortest_path.sv]
`timescale 1ns / 1ps
// dense_dijkstra_shortest_path: top level, vertex count register and solver core
// depends on dds_pkg, dds_core, dds_ram
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+----------------------------------
//  item in  | start, busy, i_item              | start high while busy low
//  result   | o_res_strobe, o_result           | one word per strobe, no stall
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data | valid and ready high
//
// edge words are taken one per cycle while busy is low. the word marked load_done starts a
// solve over the n active vertices, reading the matrix and distance memories one entry per
// cycle, then a clear of the whole MAX_VERTICES^2 matrix.
// after reset the same clear runs with busy high.
// results stream on consecutive cycles, vertex 1 first; the receiver cannot stall.

module dense_dijkstra_shortest_path #(
    parameter int MAX_VERTICES = dds_pkg::DDS_MAX_VERTICES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dds_pkg::t_item                  i_item,
    output logic                            o_res_strobe,
    output dds_pkg::t_result                o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dds_pkg::VCOUNT_W-1:0]    i_cfg_data
);

    import dds_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > VCOUNT_W) ? CW : VCOUNT_W;

    logic [VCOUNT_W-1:0] r_vertex_count;
    logic [NW-1:0]       vc_ext;
    logic [CW-1:0]       n_active;
    logic                core_busy;

    // clamp the register into the supported vertex range
    assign vc_ext = NW'(r_vertex_count);
    always_comb begin
        if (vc_ext < NW'(2)) begin
            n_active = CW'(2);
        end else if (vc_ext > NW'(MAX_VERTICES)) begin
            n_active = CW'(MAX_VERTICES);
        end else begin
            n_active = CW'(vc_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = !core_busy;
    assign busy        = core_busy;

    dds_core #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_n      (n_active),
        .o_busy   (core_busy),
        .o_strobe (o_res_strobe),
        .o_result (o_result)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> busy)
        else $error("result word outside a solve");

    a_solve_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.load_done) |=> busy)
        else $error("load_done word did not start a solve");

    a_last_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.last_result) |-> (o_result.vertex == 6'(n_active - CW'(1))))
        else $error("last flag on the wrong vertex");

    a_vertex_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_result.last_result) |=>
            (o_res_strobe && (o_result.vertex == 6'($past(o_result.vertex) + 6'd1))))
        else $error("result words not consecutive in vertex order");

endmodule

[sim/dds_sp_checker.sv]
`timescale 1ns / 1ps
// dds_sp_checker: watches the edge, result and config channels of the shortest-path block,
// recomputes the distances on every solve and compares each result word in order
// depends on dds_pkg

module dds_sp_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  dds_pkg::t_item               i_item,
    input  logic                         i_res_strobe,
    input  dds_pkg::t_result             i_result,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [dds_pkg::VCOUNT_W-1:0] i_cfg_data,
    output int                           o_pending,
    output int                           o_errors
);

    import dds_pkg::*;

    // adjacency entries hold weight+1, zero means no edge
    logic [MAT_W-1:0]    edge_tab [DDS_MAX_VERTICES][DDS_MAX_VERTICES];
    logic [DIST_W-1:0]   dist_tab [DDS_MAX_VERTICES];
    logic                settled  [DDS_MAX_VERTICES];
    logic [VCOUNT_W-1:0] vcount;
    t_result             dist_q [$];
    int                  err_cnt = 0;

    assign o_errors = err_cnt;

    function automatic void clear_edges();
        for (int f = 0; f < DDS_MAX_VERTICES; f++) begin
            for (int t = 0; t < DDS_MAX_VERTICES; t++) begin
                edge_tab[f][t] = '0;
            end
        end
    endfunction

    // dense dijkstra from vertex 0, queues one word per vertex 1 .. n-1
    function automatic void solve_distances();
        int          n;
        int          u;
        logic        found;
        logic [31:0] cand;
        logic [31:0] direct;
        t_result     word;
        if (vcount < 7'd2) n = 2;
        else if (int'(vcount) > DDS_MAX_VERTICES) n = DDS_MAX_VERTICES;
        else n = int'(vcount);
        for (int v = 1; v < n; v++) begin
            direct = {16'h0, edge_tab[0][v]} - 32'd1;
            dist_tab[v] = (edge_tab[0][v] == '0) ? DIST_INF : direct[DIST_W-1:0];
            settled[v] = 1'b0;
        end
        for (int pass = 1; pass < n; pass++) begin
            found = 1'b0;
            u = 0;
            for (int v = 1; v < n; v++) begin
                if (!settled[v] && (!found || dist_tab[v] < dist_tab[u])) begin
                    u = v;
                    found = 1'b1;
                end
            end
            if (found) begin
                settled[u] = 1'b1;
                for (int v = 1; v < n; v++) begin
                    if (!settled[v] && edge_tab[u][v] != '0) begin
                        cand = {2'b00, dist_tab[u]} + {16'h0, edge_tab[u][v]} - 32'd1;
                        if ({2'b00, dist_tab[v]} > cand) dist_tab[v] = cand[DIST_W-1:0];
                    end
                end
            end
        end
        for (int v = 1; v < n; v++) begin
            word.vertex      = 6'(v);
            word.distance    = dist_tab[v];
            word.last_result = (v == n - 1);
            dist_q.push_back(word);
        end
        clear_edges();
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            clear_edges();
            vcount = VCOUNT_RESET;
            dist_q.delete();
            o_pending <= 0;
        end else begin
            if (i_res_strobe) begin
                if (dist_q.size() == 0) begin
                    $error("result word for vertex %0d with none expected", i_result.vertex);
                    err_cnt++;
                end else begin
                    want = dist_q.pop_front();
                    if (i_result.vertex !== want.vertex) begin
                        $error("vertex: expected %0d, got %0d", want.vertex, i_result.vertex);
                        err_cnt++;
                    end
                    if (i_result.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, i_result.distance);
                        err_cnt++;
                    end
                    if (i_result.last_result !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, i_result.last_result);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) vcount = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_item.edge_valid) begin
                    edge_tab[i_item.edge_from][i_item.edge_to] = {1'b0, i_item.edge_weight} + 16'd1;
                end
                if (i_item.load_done) solve_distances();
            end
            o_pending <= dist_q.size();
        end
    end

endmodule

[sim/dense_dijkstra_shortest_path_tb.sv]
`timescale 1ns / 1ps
// dense_dijkstra_shortest_path_tb: edge word stimulus, vertex count writes and verdict
// depends on dds_pkg, dense_dijkstra_shortest_path and dds_sp_checker

module dense_dijkstra_shortest_path_tb;

    import dds_pkg::*;

    // the quiet limit covers a 64-vertex solve and the matrix clear after it
    localparam int QUIET_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 83;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_item               item = '0;
    logic                res_strobe;
    t_result             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VCOUNT_W-1:0] cfg_data = '0;

    int pending;
    int errors;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int vcount_now = VCOUNT_RESET;
    int random_items = 0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    dense_dijkstra_shortest_path u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (item),
        .o_res_strobe (res_strobe),
        .o_result     (result),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    dds_sp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_res_strobe (res_strobe),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always @(posedge clk) begin
        if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("dense_dijkstra_shortest_path test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_item edge_word(input int valid, input int from, input int to,
                                        input int wt, input int done);
        t_item w;
        w.edge_valid  = 1'(valid);
        w.edge_from   = 6'(from);
        w.edge_to     = 6'(to);
        w.edge_weight = 15'(wt);
        w.load_done   = 1'(done);
        return w;
    endfunction

    // start stays high across back-to-back words, it only drops while idling
    task automatic send_word(input t_item w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
    endtask

    // wait for all expected words and for the matrix clear behind them
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [VCOUNT_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        vcount_now = val;
    endtask

    // one graph: mostly in-range edges, some empty words and stray endpoints
    task automatic random_graph();
        int    n;
        int    edges;
        int    roll;
        t_item w;
        if (vcount_now < 2) n = 2;
        else if (vcount_now > DDS_MAX_VERTICES) n = DDS_MAX_VERTICES;
        else n = vcount_now;
        edges = $urandom_range((n < 8) ? 2 * n : 14);
        for (int k = 0; k <= edges; k++) begin
            roll = $urandom_range(99);
            w.edge_valid = (roll >= 8);
            if (roll < 20) begin
                w.edge_from = 6'($urandom);
                w.edge_to   = 6'($urandom);
            end else begin
                w.edge_from = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(n - 1));
                w.edge_to   = 6'($urandom_range(n - 1));
            end
            roll = $urandom_range(99);
            if (roll < 65) w.edge_weight = 15'($urandom_range(20));
            else if (roll < 90) w.edge_weight = 15'($urandom_range(2000));
            else w.edge_weight = 15'($urandom_range(32766));
            w.load_done = (k == edges);
            if (k == edges) w.edge_valid = 1'($urandom_range(1));
            send_word(w);
        end
        random_items += edges + 1;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // full 64-vertex graph: overwrite, tie, relaxation, loops, longest weights
        send_word(edge_word(1, 0, 1, 0, 0));
        send_word(edge_word(1, 0, 2, 100, 0));
        send_word(edge_word(1, 0, 2, 7, 0));
        send_word(edge_word(1, 0, 4, 10, 0));
        send_word(edge_word(1, 0, 5, 10, 0));
        send_word(edge_word(1, 4, 6, 5, 0));
        send_word(edge_word(1, 5, 6, 5, 0));
        send_word(edge_word(1, 1, 3, 9, 0));
        send_word(edge_word(1, 2, 3, 1, 0));
        send_word(edge_word(1, 1, 0, 0, 0));
        send_word(edge_word(1, 3, 3, 0, 0));
        send_word(edge_word(1, 0, 63, 32766, 0));
        send_word(edge_word(1, 63, 62, 32766, 0));
        send_word(edge_word(1, 62, 61, 0, 0));
        send_word(edge_word(0, 0, 7, 1, 0));
        send_word(edge_word(0, 0, 8, 3, 1));

        // count 0 acts as 2; an edge beyond the count is stored but unused
        set_vertex_count(7'd0);
        send_word(edge_word(1, 0, 5, 1, 0));
        send_word(edge_word(1, 0, 1, 32766, 1));

        // count above the maximum; the matrix must come back empty
        set_vertex_count(7'd127);
        send_word(edge_word(0, 63, 63, 32766, 1));

        set_vertex_count(7'd1);
        send_word(edge_word(1, 0, 1, 5, 0));
        send_word(edge_word(0, 63, 0, 32766, 1));

        for (int p = 0; p < 3; p++) begin
            idle_pct = (p == 0) ? 0 : (p == 1) ? 65 : 32;
            wait_idle();
            while (random_items < (p + 1) * PHASE_ITEMS) begin
                if ($urandom_range(99) < 40) begin
                    case ($urandom_range(9))
                        0:       set_vertex_count(7'($urandom_range(1)));
                        1:       set_vertex_count(7'($urandom_range(65, 127)));
                        2:       set_vertex_count(7'd64);
                        3:       set_vertex_count(7'($urandom_range(13, 63)));
                        default: set_vertex_count(7'($urandom_range(2, 12)));
                    endcase
                end
                random_graph();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("dense_dijkstra_shortest_path test passed");
        end else begin
            $display("dense_dijkstra_shortest_path test failed");
        end
        $finish;
    end

endmodule
